/* rtl/mcr_pkg.sv */
// ----------------------------------------------------------------------------
// mcr_pkg
// shared codes, defaults and the sequencer state type of the cursor remapper
// ----------------------------------------------------------------------------
package mcr_pkg;

   localparam int MAX_MONITORS_DEF = 8;
   localparam int PIXEL_BITS_DEF   = 16;
   localparam int PHYS_BITS_DEF    = 24;

   localparam int GAP_TOL_LSB = 3;

   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int COUNT_W    = 4;
   localparam int JUMP_W     = 15;

   localparam logic [OPCODE_W-1:0] OP_LOAD      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PASS     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MOVE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BLOCK    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_MONITOR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_JUMP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_GAPS     = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LK_SCAN,
      S_LK_FX,
      S_LK_FY,
      S_LK_DONE,
      S_TR_CUR,
      S_TR_CHK,
      S_TR_FX,
      S_TR_FY,
      S_TR_SC0,
      S_TR_SCAN,
      S_GAP,
      S_GAP_END,
      S_TR_PX,
      S_TR_PY,
      S_TR_DONE,
      S_CV_MUL,
      S_CV_DIV,
      S_CV_FIX,
      S_OUT
   } seq_state_type;

endpackage

/* rtl/mcr_if.sv */
// ----------------------------------------------------------------------------
// mcr channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface mcr_req_if
   import mcr_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int PHYS_BITS  = PHYS_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [OPCODE_W-1:0]           opcode;
   logic [INDEX_W-1:0]            monitor_index;
   logic signed [PIXEL_BITS-1:0]  rect_left;
   logic signed [PIXEL_BITS-1:0]  rect_top;
   logic signed [PIXEL_BITS-1:0]  rect_right;
   logic signed [PIXEL_BITS-1:0]  rect_bottom;
   logic signed [PHYS_BITS-1:0]   phys_left;
   logic signed [PHYS_BITS-1:0]   phys_top;
   logic [PHYS_BITS-2:0]          phys_width;
   logic [PHYS_BITS-2:0]          phys_height;
   logic signed [PIXEL_BITS-1:0]  point_x;
   logic signed [PIXEL_BITS-1:0]  point_y;

   modport source (output valid, opcode, monitor_index, rect_left, rect_top, rect_right,
                   rect_bottom, phys_left, phys_top, phys_width, phys_height, point_x,
                   point_y, input ready);
   modport sink   (input valid, opcode, monitor_index, rect_left, rect_top, rect_right,
                   rect_bottom, phys_left, phys_top, phys_width, phys_height, point_x,
                   point_y, output ready);
endinterface

interface mcr_rsp_if
   import mcr_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int PHYS_BITS  = PHYS_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [STATUS_W-1:0]           status;
   logic signed [PIXEL_BITS-1:0]  new_x;
   logic signed [PIXEL_BITS-1:0]  new_y;
   logic signed [PHYS_BITS-1:0]   phys_x;
   logic signed [PHYS_BITS-1:0]   phys_y;
   logic [INDEX_W-1:0]            hit_monitor;

   modport source (output valid, status, new_x, new_y, phys_x, phys_y, hit_monitor,
                   input ready);
   modport sink   (input valid, status, new_x, new_y, phys_x, phys_y, hit_monitor,
                   output ready);
endinterface

interface mcr_csr_if
   import mcr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/monitor_cursor_remap_top.sv */
// ----------------------------------------------------------------------------
// monitor_cursor_remap_top
// Cursor remapper over a table of monitors. One item is handled at a time;
// the request side is not ready until its result has been taken. Every
// pixel/physical conversion goes through one shared multiplier and a
// restoring divider that yields one quotient bit a cycle. A lookup takes up
// to one scan of the table plus two conversions; a translate takes up to
// three scans of the table plus four conversions. Table reads are
// registered, one entry a cycle.
// ----------------------------------------------------------------------------
module monitor_cursor_remap_top
   import mcr_pkg::*;
#(
   parameter int MAX_MONITORS = MAX_MONITORS_DEF,
   parameter int PIXEL_BITS   = PIXEL_BITS_DEF,
   parameter int PHYS_BITS    = PHYS_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcr_req_if.sink    req_ch,
   mcr_rsp_if.source  rsp_ch,
   mcr_csr_if.sink    csr_ch
);

   localparam int PW  = PIXEL_BITS;
   localparam int FW  = PHYS_BITS;
   localparam int MA  = PW + 3;
   localparam int MB  = FW + 1;
   localparam int PRW = MA + MB;
   localparam int WW  = PRW + 2;
   localparam int DNW = (PW + 2 > FW) ? PW + 2 : FW;
   localparam int DCW = $clog2(PRW + 1);
   localparam int IW  = (MAX_MONITORS > 1) ? $clog2(MAX_MONITORS) : 1;
   localparam int CW  = $clog2(MAX_MONITORS + 1);

   localparam logic signed [WW-1:0] GapLim = -WW'(GAP_TOL_LSB);
   localparam logic signed [WW-1:0] One    = WW'(1);
   localparam logic signed [WW-1:0] PixHi  = (One <<< (PW - 1)) - One;
   localparam logic signed [WW-1:0] PixLo  = -PixHi - One;
   localparam logic signed [WW-1:0] PhyHi  = (One <<< (FW - 1)) - One;
   localparam logic signed [WW-1:0] PhyLo  = -PhyHi - One;

   typedef struct packed {
      logic [PW-1:0]   left;
      logic [PW-1:0]   top;
      logic [PW-1:0]   right;
      logic [PW-1:0]   bottom;
      logic [FW-1:0]   xmm;
      logic [FW-1:0]   ymm;
      logic [FW-2:0]   wmm;
      logic [FW-2:0]   hmm;
   } entry_type;

   function automatic logic signed [WW-1:0] pos1(input logic signed [WW-1:0] v);
      return (v > 0) ? v : One;
   endfunction

   function automatic logic signed [WW-1:0] clampv(input logic signed [WW-1:0] v,
                                                   input logic signed [WW-1:0] lo,
                                                   input logic signed [WW-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // monitor table
   entry_type table_mem [MAX_MONITORS];
   entry_type entry_ff;

   seq_state_type state_ff, state_in, ret_ff, ret_in;

   logic [COUNT_W-1:0] mcount_ff, mcount_in;
   logic [JUMP_W-1:0]  mjump_ff, mjump_in;
   logic               jgaps_ff, jgaps_in;

   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [PW-1:0]        ptx_ff, ptx_in, pty_ff, pty_in;
   logic [IW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        i_ff, i_in;
   entry_type            cur_ff, cur_in, tgt_ff, tgt_in;
   logic signed [WW-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic                 horiz_ff, horiz_in, bestv_ff, bestv_in;
   logic signed [WW-1:0] bestd_ff, bestd_in;

   logic [STATUS_W-1:0]  st_ff, st_in;
   logic signed [WW-1:0] nx_ff, nx_in, ny_ff, ny_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [INDEX_W-1:0]   hit_ff, hit_in;

   // shared conversion unit
   logic signed [MA-1:0]  ma_ff, ma_in;
   logic signed [MB-1:0]  mb_ff, mb_in;
   logic [DNW-1:0]        den_ff, den_in;
   logic signed [WW-1:0]  off_ff, off_in;
   logic [PRW-1:0]        quo_ff, quo_in;
   logic [DNW-1:0]        rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [DCW-1:0]        dcnt_ff, dcnt_in;
   logic signed [WW-1:0]  res_ff, res_in;

   logic signed [PRW-1:0] prod;
   logic [DNW:0]          trial;
   logic signed [WW-1:0]  qw;

   logic [CW-1:0]        used_cnt;
   logic                 scan_end, i_is_cur;
   logic signed [WW-1:0] px, py;
   logic signed [WW-1:0] el, et, er, eb, ex, ey, ew, eh;
   logic signed [WW-1:0] cl, ct, cr, cb, cx, cy, cw, ch;
   logic signed [WW-1:0] tl, tt, tr, tb, tx, ty, tw, th;
   logic signed [WW-1:0] sl, st, sr, sb, sx, sy, sw, sh;
   logic signed [WW-1:0] over, o1, o2, o3, o4, gap_dist, mjw;
   logic                 pix_in, phys_in, range_ok;
   logic                 dxn, dxp, dyn, dyp;
   entry_type            src;

   // ------------------------------------------------------------------
   // datapath views
   // ------------------------------------------------------------------
   always_comb begin
      used_cnt = (32'(mcount_ff) > MAX_MONITORS) ? CW'(MAX_MONITORS) : CW'(mcount_ff);
      scan_end = (32'(i_ff) >= 32'(used_cnt));
      i_is_cur = (32'(i_ff) == 32'(idx_ff));
      px = WW'($signed(ptx_ff));
      py = WW'($signed(pty_ff));

      el = WW'($signed(entry_ff.left));   et = WW'($signed(entry_ff.top));
      er = WW'($signed(entry_ff.right));  eb = WW'($signed(entry_ff.bottom));
      ex = WW'($signed(entry_ff.xmm));    ey = WW'($signed(entry_ff.ymm));
      ew = WW'({1'b0, entry_ff.wmm});     eh = WW'({1'b0, entry_ff.hmm});

      cl = WW'($signed(cur_ff.left));     ct = WW'($signed(cur_ff.top));
      cr = WW'($signed(cur_ff.right));    cb = WW'($signed(cur_ff.bottom));
      cx = WW'($signed(cur_ff.xmm));      cy = WW'($signed(cur_ff.ymm));
      cw = WW'({1'b0, cur_ff.wmm});       ch = WW'({1'b0, cur_ff.hmm});

      tl = WW'($signed(tgt_ff.left));     tt = WW'($signed(tgt_ff.top));
      tr = WW'($signed(tgt_ff.right));    tb = WW'($signed(tgt_ff.bottom));
      tx = WW'($signed(tgt_ff.xmm));      ty = WW'($signed(tgt_ff.ymm));
      tw = WW'({1'b0, tgt_ff.wmm});       th = WW'({1'b0, tgt_ff.hmm});

      // lookup converts from the found entry, translate from the current one
      src = (op_ff == OP_LOOKUP) ? tgt_ff : cur_ff;
      sl = WW'($signed(src.left));        st = WW'($signed(src.top));
      sr = WW'($signed(src.right));       sb = WW'($signed(src.bottom));
      sx = WW'($signed(src.xmm));         sy = WW'($signed(src.ymm));
      sw = WW'({1'b0, src.wmm});          sh = WW'({1'b0, src.hmm});

      pix_in  = (px >= el) && (px < er) && (py >= et) && (py < eb);
      phys_in = (fx_ff >= ex) && (fx_ff < ex + ew) && (fy_ff >= ey) && (fy_ff < ey + eh);

      o1 = cl - px;
      o2 = px - (cr - One);
      o3 = ct - py;
      o4 = py - (cb - One);
      over = o1;
      if (o2 > over) over = o2;
      if (o3 > over) over = o3;
      if (o4 > over) over = o4;
      mjw = WW'($signed({1'b0, mjump_ff}));

      dxn = (px < cl);
      dxp = !dxn && (px >= cr);
      dyn = (py < ct);
      dyp = !dyn && (py >= cb);

      if (horiz_ff) begin
         range_ok = (fy_ff >= ey) && (fy_ff < ey + eh);
         gap_dist = dxp ? ex - (cx + cw) : cx - (ex + ew);
      end else begin
         range_ok = (fx_ff >= ex) && (fx_ff < ex + ew);
         gap_dist = dyp ? ey - (cy + ch) : cy - (ey + eh);
      end

      prod  = PRW'(ma_ff) * PRW'(mb_ff);
      trial = {rem_ff, quo_ff[PRW-1]};
      qw    = WW'({2'b00, quo_ff});
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      mcount_in = mcount_ff;
      mjump_in  = mjump_ff;
      jgaps_in  = jgaps_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      ptx_in    = ptx_ff;
      pty_in    = pty_ff;
      addr_in   = addr_ff;
      i_in      = i_ff;
      cur_in    = cur_ff;
      tgt_in    = tgt_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      horiz_in  = horiz_ff;
      bestv_in  = bestv_ff;
      bestd_in  = bestd_ff;
      st_in     = st_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      hit_in    = hit_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      den_in    = den_ff;
      off_in    = off_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      dcnt_in   = dcnt_ff;
      res_in    = res_ff;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_MONITOR_COUNT: mcount_in = csr_ch.data[COUNT_W-1:0];
            REG_MAX_JUMP:      mjump_in  = csr_ch.data[JUMP_W-1:0];
            REG_JUMP_GAPS:     jgaps_in  = csr_ch.data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in  = req_ch.opcode;
               idx_in = req_ch.monitor_index;
               ptx_in = req_ch.point_x;
               pty_in = req_ch.point_y;
               nx_in  = '0;
               ny_in  = '0;
               ox_in  = '0;
               oy_in  = '0;
               hit_in = '0;
               case (req_ch.opcode)
                  OP_LOAD: begin
                     st_in    = ST_LOADED;
                     state_in = S_OUT;
                  end
                  OP_TRANSLATE: begin
                     addr_in  = IW'(req_ch.monitor_index);
                     state_in = S_TR_CUR;
                  end
                  OP_LOOKUP: begin
                     i_in     = '0;
                     addr_in  = '0;
                     state_in = S_LK_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         S_LK_SCAN: begin
            if (scan_end) begin
               st_in    = ST_NOTFOUND;
               state_in = S_OUT;
            end else if (pix_in) begin
               tgt_in   = entry_ff;
               hit_in   = INDEX_W'(i_ff);
               state_in = S_LK_FX;
            end else begin
               i_in    = i_ff + CW'(1);
               addr_in = IW'(i_in);
            end
         end

         S_LK_FX, S_TR_FX: begin
            ma_in    = MA'(WW'(2) * (px - sl) + One);
            mb_in    = MB'(sw);
            den_in   = DNW'(WW'(2) * pos1(sr - sl));
            off_in   = sx;
            ret_in   = (state_ff == S_LK_FX) ? S_LK_FY : S_TR_FY;
            state_in = S_CV_MUL;
         end

         S_LK_FY, S_TR_FY: begin
            if (state_ff == S_LK_FY) begin
               ox_in  = res_ff;
               ret_in = S_LK_DONE;
            end else begin
               fx_in  = res_ff;
               ret_in = S_TR_SC0;
            end
            ma_in    = MA'(WW'(2) * (py - st) + One);
            mb_in    = MB'(sh);
            den_in   = DNW'(WW'(2) * pos1(sb - st));
            off_in   = sy;
            state_in = S_CV_MUL;
         end

         S_LK_DONE: begin
            oy_in    = res_ff;
            st_in    = ST_FOUND;
            state_in = S_OUT;
         end

         S_TR_CUR: begin
            cur_in   = entry_ff;
            state_in = S_TR_CHK;
         end

         S_TR_CHK: begin
            if (32'(idx_ff) >= 32'(used_cnt)
                || ((px >= cl) && (px < cr) && (py >= ct) && (py < cb))
                || ((mjump_ff != '0) && (over > mjw))) begin
               st_in    = ST_PASS;
               state_in = S_OUT;
            end else begin
               state_in = S_TR_FX;
            end
         end

         S_TR_SC0: begin
            fy_in    = res_ff;
            i_in     = '0;
            addr_in  = '0;
            state_in = S_TR_SCAN;
         end

         S_TR_SCAN: begin
            if (scan_end) begin
               i_in     = '0;
               addr_in  = '0;
               bestv_in = 1'b0;
               if (jgaps_ff && (dxn || dxp)) begin
                  horiz_in = 1'b1;
                  state_in = S_GAP;
               end else if (jgaps_ff && (dyn || dyp)) begin
                  horiz_in = 1'b0;
                  state_in = S_GAP;
               end else begin
                  nx_in    = clampv(px, cl, cr - One);
                  ny_in    = clampv(py, ct, cb - One);
                  st_in    = ST_BLOCK;
                  state_in = S_OUT;
               end
            end else if (!i_is_cur && phys_in) begin
               tgt_in   = entry_ff;
               hit_in   = INDEX_W'(i_ff);
               state_in = S_TR_PX;
            end else begin
               i_in    = i_ff + CW'(1);
               addr_in = IW'(i_in);
            end
         end

         S_GAP: begin
            if (scan_end) begin
               state_in = S_GAP_END;
            end else begin
               // nearest monitor across the gap, within the tolerance
               if (!i_is_cur && range_ok && !(gap_dist < GapLim)
                   && (!bestv_ff || (gap_dist < bestd_ff))) begin
                  bestv_in = 1'b1;
                  bestd_in = gap_dist;
                  tgt_in   = entry_ff;
                  hit_in   = INDEX_W'(i_ff);
               end
               i_in    = i_ff + CW'(1);
               addr_in = IW'(i_in);
            end
         end

         S_GAP_END: begin
            if (bestv_ff) begin
               if (horiz_ff) fx_in = dxp ? tx : tx + tw - One;
               else          fy_in = dyp ? ty : ty + th - One;
               state_in = S_TR_PX;
            end else if (horiz_ff && (dyn || dyp)) begin
               horiz_in = 1'b0;
               i_in     = '0;
               addr_in  = '0;
               state_in = S_GAP;
            end else begin
               hit_in   = '0;
               nx_in    = clampv(px, cl, cr - One);
               ny_in    = clampv(py, ct, cb - One);
               st_in    = ST_BLOCK;
               state_in = S_OUT;
            end
         end

         S_TR_PX: begin
            ma_in    = MA'(pos1(tr - tl));
            mb_in    = MB'(fx_ff - tx);
            den_in   = DNW'(pos1(tw));
            off_in   = tl;
            ret_in   = S_TR_PY;
            state_in = S_CV_MUL;
         end

         S_TR_PY: begin
            nx_in    = clampv(res_ff, tl, tr - One);
            ma_in    = MA'(pos1(tb - tt));
            mb_in    = MB'(fy_ff - ty);
            den_in   = DNW'(pos1(th));
            off_in   = tt;
            ret_in   = S_TR_DONE;
            state_in = S_CV_MUL;
         end

         S_TR_DONE: begin
            ny_in    = clampv(res_ff, tt, tb - One);
            st_in    = ST_MOVE;
            state_in = S_OUT;
         end

         S_CV_MUL: begin
            neg_in   = prod[PRW-1];
            quo_in   = prod[PRW-1] ? PRW'(-prod) : PRW'(prod);
            rem_in   = '0;
            dcnt_in  = DCW'(PRW);
            state_in = S_CV_DIV;
         end

         S_CV_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DNW'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[PRW-2:0], 1'b1};
            end else begin
               rem_in = DNW'(trial);
               quo_in = {quo_ff[PRW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) state_in = S_CV_FIX;
         end

         S_CV_FIX: begin
            // floor for negative numerators
            if (neg_ff) res_in = off_ff - qw - ((rem_ff != '0) ? One : '0);
            else        res_in = off_ff + qw;
            state_in = ret_ff;
         end

         S_OUT: begin
            if (rsp_ch.ready) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         mcount_ff <= '0;
         mjump_ff  <= '0;
         jgaps_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         mcount_ff <= mcount_in;
         mjump_ff  <= mjump_in;
         jgaps_ff  <= jgaps_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      ptx_ff   <= ptx_in;
      pty_ff   <= pty_in;
      addr_ff  <= addr_in;
      i_ff     <= i_in;
      cur_ff   <= cur_in;
      tgt_ff   <= tgt_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      horiz_ff <= horiz_in;
      bestv_ff <= bestv_in;
      bestd_ff <= bestd_in;
      st_ff    <= st_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      hit_ff   <= hit_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      den_ff   <= den_in;
      off_ff   <= off_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      dcnt_ff  <= dcnt_in;
      res_ff   <= res_in;
   end

   // table write on load, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_ch.valid && req_ch.opcode == OP_LOAD
          && 32'(req_ch.monitor_index) < MAX_MONITORS) begin
         table_mem[IW'(req_ch.monitor_index)] <= '{
            left:   req_ch.rect_left,
            top:    req_ch.rect_top,
            right:  req_ch.rect_right,
            bottom: req_ch.rect_bottom,
            xmm:    req_ch.phys_left,
            ymm:    req_ch.phys_top,
            wmm:    req_ch.phys_width,
            hmm:    req_ch.phys_height
         };
      end
      entry_ff <= table_mem[addr_in];
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = (state_ff == S_OUT);
   assign rsp_ch.status      = st_ff;
   assign rsp_ch.new_x       = PW'(clampv(nx_ff, PixLo, PixHi));
   assign rsp_ch.new_y       = PW'(clampv(ny_ff, PixLo, PixHi));
   assign rsp_ch.phys_x      = FW'(clampv(ox_ff, PhyLo, PhyHi));
   assign rsp_ch.phys_y      = FW'(clampv(oy_ff, PhyLo, PhyHi));
   assign rsp_ch.hit_monitor = hit_ff;

endmodule

/* sim/monitor_cursor_remap_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monitor_cursor_remap_top_test
// Self-checking bench for the cursor remapper. A table of monitor entries is
// loaded, then lookup and translate items are sent in random bursts while the
// response side stalls. Every response is checked against an internal
// prediction of the table, the scaling arithmetic and the gap search.
// ----------------------------------------------------------------------------
module monitor_cursor_remap_top_test;
   import mcr_pkg::*;

   localparam int NMON = 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      longint left, top, right, bottom, xmm, ymm, wmm, hmm;
   } screen_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      longint nx, ny, ox, oy;
      int hit;
   } remap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcr_req_if req_ch ();
   mcr_rsp_if rsp_ch ();
   mcr_csr_if csr_ch ();

   monitor_cursor_remap_top dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   always #6 clock = ~clock;

   screen_type screens [NMON];
   bit loaded [NMON];
   int unsigned screen_count;
   int unsigned jump_limit;
   bit gap_jumps;

   remap_result_type pending_results [$];
   int errors = 0;
   int idle_cycles = 0;
   bit long_hold = 1'b0;
   bit stall_enable = 1'b1;

   // ---------------------------------------------------------------- arithmetic
   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
      return q;
   endfunction

   function automatic longint sat(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return v < -hi - 1 ? -hi - 1 : v > hi ? hi : v;
   endfunction

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : v > hi ? hi : v;
   endfunction

   function automatic longint pos1(longint v);
      return v > 0 ? v : 1;
   endfunction

   function automatic longint pix_to_mm(longint org, longint sz, longint p,
                                        longint pe, longint pend);
      return org + fdiv((2 * (p - pe) + 1) * sz, 2 * pos1(pend - pe));
   endfunction

   function automatic longint mm_to_pix(longint pe, longint pend, longint f,
                                        longint org, longint sz);
      return pe + fdiv((f - org) * pos1(pend - pe), pos1(sz));
   endfunction

   function automatic bit holds_pixel(screen_type m, longint x, longint y);
      return x >= m.left && x < m.right && y >= m.top && y < m.bottom;
   endfunction

   function automatic bit holds_mm(screen_type m, longint fx, longint fy);
      return fx >= m.xmm && fx < m.xmm + m.wmm && fy >= m.ymm && fy < m.ymm + m.hmm;
   endfunction

   function automatic int nearest_across_gap(int cnt, int cur, bit horiz, int dir,
                                             inout longint fx, inout longint fy);
      int best;
      longint best_dist, gap_len;
      best = -1;
      best_dist = 0;
      for (int i = 0; i < cnt; i++) begin
         if (i == cur) continue;
         if (horiz) begin
            if (fy < screens[i].ymm || fy >= screens[i].ymm + screens[i].hmm) continue;
            gap_len = dir > 0 ? screens[i].xmm - (screens[cur].xmm + screens[cur].wmm)
                              : screens[cur].xmm - (screens[i].xmm + screens[i].wmm);
         end else begin
            if (fx < screens[i].xmm || fx >= screens[i].xmm + screens[i].wmm) continue;
            gap_len = dir > 0 ? screens[i].ymm - (screens[cur].ymm + screens[cur].hmm)
                              : screens[cur].ymm - (screens[i].ymm + screens[i].hmm);
         end
         if (gap_len < -GAP_TOL_LSB || (best >= 0 && gap_len >= best_dist)) continue;
         best_dist = gap_len;
         best = i;
      end
      if (best >= 0) begin
         if (horiz) fx = dir > 0 ? screens[best].xmm : screens[best].xmm + screens[best].wmm - 1;
         else       fy = dir > 0 ? screens[best].ymm : screens[best].ymm + screens[best].hmm - 1;
      end
      return best;
   endfunction

   // works out the response of one request and updates the table copy
   function automatic remap_result_type predict_remap(logic [OPCODE_W-1:0] op, int idx,
         longint rl, longint rt, longint rr, longint rb, longint pl, longint pt,
         longint pw, longint ph, longint px, longint py);
      remap_result_type r;
      int cnt, t, dx, dy;
      longint over, fx, fy;
      screen_type c;
      r = '{status: ST_LOADED, nx: 0, ny: 0, ox: 0, oy: 0, hit: 0};
      cnt = screen_count > NMON ? NMON : screen_count;
      if (op == OP_LOAD) begin
         screens[idx] = '{rl, rt, rr, rb, pl, pt, pw, ph};
         loaded[idx] = 1'b1;
      end else if (op == OP_LOOKUP) begin
         r.status = ST_NOTFOUND;
         for (int i = 0; i < cnt; i++) begin
            if (holds_pixel(screens[i], px, py)) begin
               r.status = ST_FOUND;
               r.hit = i;
               r.ox = pix_to_mm(screens[i].xmm, screens[i].wmm, px, screens[i].left,
                                screens[i].right);
               r.oy = pix_to_mm(screens[i].ymm, screens[i].hmm, py, screens[i].top,
                                screens[i].bottom);
               break;
            end
         end
      end else if (idx >= cnt || holds_pixel(screens[idx], px, py)) begin
         r.status = ST_PASS;
      end else begin
         c = screens[idx];
         over = c.left - px;
         if (px - (c.right - 1) > over) over = px - (c.right - 1);
         if (c.top - py > over) over = c.top - py;
         if (py - (c.bottom - 1) > over) over = py - (c.bottom - 1);
         if (jump_limit > 0 && over > jump_limit) begin
            r.status = ST_PASS;
         end else begin
            t = -1;
            fx = pix_to_mm(c.xmm, c.wmm, px, c.left, c.right);
            fy = pix_to_mm(c.ymm, c.hmm, py, c.top, c.bottom);
            for (int i = 0; i < cnt; i++) begin
               if (i != idx && holds_mm(screens[i], fx, fy)) begin
                  t = i;
                  break;
               end
            end
            if (t < 0 && gap_jumps) begin
               dx = px < c.left ? -1 : px >= c.right ? 1 : 0;
               dy = py < c.top ? -1 : py >= c.bottom ? 1 : 0;
               if (dx != 0) t = nearest_across_gap(cnt, idx, 1'b1, dx, fx, fy);
               if (t < 0 && dy != 0) t = nearest_across_gap(cnt, idx, 1'b0, dy, fx, fy);
            end
            if (t >= 0) begin
               r.nx = clampv(mm_to_pix(screens[t].left, screens[t].right, fx,
                             screens[t].xmm, screens[t].wmm), screens[t].left,
                             screens[t].right - 1);
               r.ny = clampv(mm_to_pix(screens[t].top, screens[t].bottom, fy,
                             screens[t].ymm, screens[t].hmm), screens[t].top,
                             screens[t].bottom - 1);
               r.status = ST_MOVE;
               r.hit = t;
            end else begin
               r.nx = clampv(px, c.left, c.right - 1);
               r.ny = clampv(py, c.top, c.bottom - 1);
               r.status = ST_BLOCK;
            end
         end
      end
      r.nx = sat(r.nx, 16);
      r.ny = sat(r.ny, 16);
      r.ox = sat(r.ox, 24);
      r.oy = sat(r.oy, 24);
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_LOAD;
      req_ch.monitor_index = '0;
      req_ch.rect_left = '0;
      req_ch.rect_top = '0;
      req_ch.rect_right = '0;
      req_ch.rect_bottom = '0;
      req_ch.phys_left = '0;
      req_ch.phys_top = '0;
      req_ch.phys_width = '0;
      req_ch.phys_height = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_MONITOR_COUNT;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   int burst_left = 0;

   // sends one item; the expectation is queued when it is accepted
   // valid stays up inside a burst and drops only for a gap or a drain
   task automatic send_item(logic [OPCODE_W-1:0] op, int idx, longint rl = 0,
         longint rt = 0, longint rr = 0, longint rb = 0, longint pl = 0, longint pt = 0,
         longint pw = 1, longint ph = 1, longint px = 0, longint py = 0);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.monitor_index <= INDEX_W'(idx);
      req_ch.rect_left <= PIXEL_BITS_DEF'(rl);
      req_ch.rect_top <= PIXEL_BITS_DEF'(rt);
      req_ch.rect_right <= PIXEL_BITS_DEF'(rr);
      req_ch.rect_bottom <= PIXEL_BITS_DEF'(rb);
      req_ch.phys_left <= PHYS_BITS_DEF'(pl);
      req_ch.phys_top <= PHYS_BITS_DEF'(pt);
      req_ch.phys_width <= (PHYS_BITS_DEF - 1)'(pw);
      req_ch.phys_height <= (PHYS_BITS_DEF - 1)'(ph);
      req_ch.point_x <= PIXEL_BITS_DEF'(px);
      req_ch.point_y <= PIXEL_BITS_DEF'(py);
      do @(posedge clock); while (!req_ch.ready);
      if (op != OP_UNUSED)
         pending_results.push_back(predict_remap(op, idx, rl, rt, rr, rb, pl, pt, pw, ph,
                                                 px, py));
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_MONITOR_COUNT: screen_count = value & 15;
         REG_MAX_JUMP:      jump_limit = value & 16'h7fff;
         REG_JUMP_GAPS:     gap_jumps = value & 1;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned cnt, int unsigned lim, bit gaps);
      drain();
      write_reg(REG_MONITOR_COUNT, cnt);
      write_reg(REG_MAX_JUMP, lim);
      write_reg(REG_JUMP_GAPS, gaps);
      csr_ch.valid <= 1'b0;
   endtask

   // a row of screens side by side, some gaps and overlaps in millimetres
   task automatic load_layout(int n, bit wild);
      longint x, mmx, w, h, pw, ph;
      x = -1000;
      mmx = -20000;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(8, 400);
         h = $urandom_range(8, 400);
         pw = $urandom_range(1, 60000);
         ph = $urandom_range(1, 60000);
         if (wild && $urandom_range(0, 3) == 0) w = -$urandom_range(0, 3);
         send_item(OP_LOAD, i, x, -200 + $urandom_range(0, 100), x + w,
                   -200 + h + $urandom_range(0, 100), mmx, $urandom_range(0, 2000) - 1000,
                   pw, ph);
         x += w + $urandom_range(0, 40);
         mmx += pw + $urandom_range(0, 3) * ($urandom_range(0, 1) ? 1 : -1)
                + ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3000) : 0);
      end
   endtask

   function automatic longint near_coord(longint lo, longint hi);
      case ($urandom_range(0, 5))
         0: return lo - $urandom_range(0, 3);
         1: return hi - 1 + $urandom_range(0, 3);
         2: return lo + $urandom_range(0, 60);
         3: return $signed(16'($urandom));
         default: return lo - 40 + $urandom_range(0, 500);
      endcase
   endfunction

   task automatic random_points(int n);
      int idx, cnt;
      cnt = screen_count > NMON ? NMON : screen_count;
      for (int k = 0; k < n; k++) begin
         idx = $urandom_range(0, NMON - 1);
         if (idx >= cnt || !loaded[idx]) idx = cnt == 0 ? 0 : $urandom_range(0, cnt - 1);
         if ($urandom_range(0, 3) == 0)
            send_item(OP_LOOKUP, idx, .px(near_coord(screens[idx].left, screens[idx].right)),
                      .py(near_coord(screens[idx].top, screens[idx].bottom)));
         else
            send_item(OP_TRANSLATE, idx,
                      .px(near_coord(screens[idx].left, screens[idx].right)),
                      .py(near_coord(screens[idx].top, screens[idx].bottom)));
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed;
      // boundary loads with extreme fields
      send_item(OP_LOAD, 0, -32768, -32768, 32767, 32767, -8388608, -8388608, 8388607,
                8388607);
      send_item(OP_LOAD, 1, 32767, 32767, -32768, -32768, 8388607, 8388607, 1, 1);
      send_item(OP_LOAD, 2, 0, 0, 1920, 1080, 0, 0, 132000, 74000);
      send_item(OP_LOAD, 3, 1920, 0, 3840, 1080, 132001, 0, 132000, 74000);
      send_item(OP_LOAD, 4, 0, 1080, 1920, 2160, 0, 80000, 132000, 74000);
      send_item(OP_LOAD, 5, 5000, 5000, 5000, 5000, 0, 0, 0, 0);
      send_item(OP_LOAD, 6, -100, -100, 0, 0, -9000, -9000, 9000, 9000);
      send_item(OP_LOAD, 7, 4000, 0, 4100, 100, 400000, 0, 8000, 8000);
      // unknown opcode gives no result
      send_item(OP_UNUSED, 7, .px(-1), .py(-1));
      set_regs(8, 0, 1'b1);
      send_item(OP_LOOKUP, 0, .px(-32768), .py(-32768));
      send_item(OP_LOOKUP, 0, .px(32767), .py(32767));
      send_item(OP_LOOKUP, 0, .px(100), .py(100));
      send_item(OP_TRANSLATE, 2, .px(1920), .py(500));
      send_item(OP_TRANSLATE, 2, .px(500), .py(1080));
      send_item(OP_TRANSLATE, 3, .px(1919), .py(10));
      send_item(OP_TRANSLATE, 2, .px(-5), .py(-5));
      send_item(OP_TRANSLATE, 5, .px(5000), .py(5000));
      send_item(OP_TRANSLATE, 1, .px(0), .py(0));
      send_item(OP_TRANSLATE, 7, .px(4100), .py(50));
      set_regs(2, 32767, 1'b0);
      send_item(OP_TRANSLATE, 7, .px(0), .py(0));
      send_item(OP_TRANSLATE, 0, .px(10), .py(10));
      set_regs(15, 1, 1'b0);
      send_item(OP_TRANSLATE, 2, .px(1925), .py(10));
      send_item(OP_TRANSLATE, 2, .px(1920), .py(10));
      send_item(OP_LOOKUP, 0, .px(4050), .py(50));
   endtask

   task automatic test_random_layouts;
      int unsigned lim;
      for (int round = 0; round < 12; round++) begin
         set_regs(0, 0, 1'b0);
         load_layout(NMON, round % 3 == 2);
         lim = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 80);
         set_regs($urandom_range(0, 15), lim, $urandom_range(0, 1));
         random_points(55);
      end
   endtask

   task automatic test_backpressure;
      long_hold = 1'b1;
      random_points(20);
      long_hold = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NMON; i++) begin
         screens[i] = '{0, 0, 0, 0, 0, 0, 0, 0};
         loaded[i] = 1'b0;
      end
      screen_count = 0;
      jump_limit = 0;
      gap_jumps = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_layouts();
      test_backpressure();
      drain();
      if (errors == 0 && pending_results.size() == 0)
         $display("[monitor_cursor_remap_top] OK");
      else
         $display("[monitor_cursor_remap_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold) begin
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 50) begin
         rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // a long hold-off so the block backs up its request side
   initial begin
      wait (long_hold);
      repeat (600) @(posedge clock);
      long_hold = 1'b0;
   end

   always @(posedge clock) begin
      remap_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item status %0d", $time, rsp_ch.status);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_ch.status !== e.status || rsp_ch.new_x !== 16'(e.nx)
                || rsp_ch.new_y !== 16'(e.ny) || rsp_ch.phys_x !== 24'(e.ox)
                || rsp_ch.phys_y !== 24'(e.oy) || rsp_ch.hit_monitor !== 3'(e.hit)) begin
               $display("%0t: mismatch expected st=%0d x=%0d y=%0d px=%0d py=%0d hit=%0d",
                        $time, e.status, e.nx, e.ny, e.ox, e.oy, e.hit);
               $display("%0t:          actual   st=%0d x=%0d y=%0d px=%0d py=%0d hit=%0d",
                        $time, rsp_ch.status, rsp_ch.new_x, rsp_ch.new_y, rsp_ch.phys_x,
                        rsp_ch.phys_y, rsp_ch.hit_monitor);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready) || reset || !(req_ch.valid || csr_ch.valid
          || pending_results.size() != 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[monitor_cursor_remap_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
